FILE: hdl/swe_pkg.sv
// swe_pkg: shared widths, request codes and reset values of the
// sliding-window energy core. No dependencies.
`default_nettype none
package swe_pkg;

   localparam int WINDOW_LEN_W = 11;
   localparam int SAMPLE_W     = 16;
   localparam int ENERGY_W     = 32;

   localparam logic [WINDOW_LEN_W-1:0] WINDOW_LEN_RESET = 11'd1024;

   // request operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef logic [ENERGY_W-1:0]     energy_type;
   typedef logic [SAMPLE_W-1:0]     sample_type;
   typedef logic [WINDOW_LEN_W-1:0] window_len_type;

endpackage
`default_nettype wire

FILE: hdl/sliding_window_energy_core.sv
// Sliding-window energy core: ring memory of recent samples and a running
// sum of their squares, updated through one shared squaring unit.
// Depends on swe_pkg.
//
// Use:
//   req channel (req_valid/req_ready): req_operation inserts a sample
//   (OP_INSERT) or clears ring, index and energy (OP_CLEAR).
//   rsp channel (rsp_valid/rsp_ready): one rsp_energy per request, the sum
//   of squares modulo 2^32 after that request; zero after a clear.
//   csr_wr_en/csr_wr_data set window_length; write only while idle.
// Sequence:
//   from acceptance (ring read at acceptance) an insert steps through:
//   square of the new sample, square of the overwritten sample (the one
//   multiplier is used twice), subtract, result load. A clear goes to the
//   result load directly. req_ready is high only in the idle state, so a
//   new request waits for the previous result load. The result sits in an
//   output register; the next request is accepted while it waits, and its
//   own result load holds off until the receiver has taken the previous one.
// Reset: synchronous; ring reads as zero (a fill count marks written
//   entries, no clearing pass), index and energy zero, window_length 1024.
`default_nettype none
module sliding_window_energy_core #(
   parameter int MAX_WINDOW  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire                         req_operation,
   input  swe_pkg::sample_type         req_sample,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output swe_pkg::energy_type         rsp_energy,
   input  wire                         csr_wr_en,
   input  swe_pkg::window_len_type     csr_wr_data
);
   import swe_pkg::*;

   localparam int IDX_W  = $clog2(MAX_WINDOW);
   localparam int FILL_W = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W  = (IDX_W + 1 > WINDOW_LEN_W) ? IDX_W + 1 : WINDOW_LEN_W;
   localparam int PROD_W = 2 * SAMPLE_BITS;
   localparam logic [CMP_W-1:0]  MAX_LEN  = CMP_W'(MAX_WINDOW);
   localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_WINDOW);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQ_NEW = 3'd1;
   localparam logic [2:0] ST_SQ_OLD = 3'd2;
   localparam logic [2:0] ST_SUB    = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]             state_ff, state_in;
   window_len_type         win_len_ff, win_len_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   energy_type             energy_ff, energy_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   old_valid_ff, old_valid_in;
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   energy_type             rsp_energy_ff, rsp_energy_in;

   logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];

   logic                   accept;
   logic                   ring_we;
   logic [SAMPLE_BITS-1:0] mul_op;
   logic [CMP_W-1:0]       len_ext, eff_len, last_slot;
   logic                   wrap;

   assign accept    = req_valid & req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_energy = rsp_energy_ff;

   // effective window: zero counts as one, saturate at the ring depth
   always_comb begin
      len_ext = CMP_W'(win_len_ff);
      if (len_ext == '0) begin
         eff_len = CMP_W'(1);
      end else if (len_ext > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = len_ext;
      end
      last_slot = eff_len - CMP_W'(1);
      wrap      = (CMP_W'(idx_ff) >= last_slot);
   end

   // shared squaring unit: new sample first, then the overwritten one
   assign mul_op  = (state_ff == ST_SQ_NEW) ? sample_ff
                  : (old_valid_ff ? rd_data_ff : '0);
   assign ring_we = (state_ff == ST_SQ_OLD);

   always_comb begin
      state_in      = state_ff;
      win_len_in    = csr_wr_en ? csr_wr_data : win_len_ff;
      idx_in        = idx_ff;
      fill_in       = fill_ff;
      energy_in     = energy_ff;
      prod_in       = prod_ff;
      sample_in     = sample_ff;
      old_valid_in  = old_valid_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_energy_in = rsp_energy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in    = req_sample[SAMPLE_BITS-1:0];
               old_valid_in = (FILL_W'(idx_ff) < fill_ff);
               if (req_operation == OP_CLEAR) begin
                  idx_in    = '0;
                  fill_in   = '0;
                  energy_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_SQ_NEW;
               end
            end
         end
         ST_SQ_NEW: begin
            prod_in  = PROD_W'(mul_op) * PROD_W'(mul_op);
            state_in = ST_SQ_OLD;
         end
         ST_SQ_OLD: begin
            energy_in = energy_ff + ENERGY_W'(prod_ff);
            prod_in   = PROD_W'(mul_op) * PROD_W'(mul_op);
            idx_in    = wrap ? '0 : idx_ff + IDX_W'(1);
            if (!old_valid_ff) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            state_in = ST_SUB;
         end
         ST_SUB: begin
            energy_in = energy_ff - ENERGY_W'(prod_ff);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_energy_in = energy_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_len_ff   <= WINDOW_LEN_RESET;
         idx_ff       <= '0;
         fill_ff      <= '0;
         energy_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_len_ff   <= win_len_in;
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
         energy_ff    <= energy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      sample_ff     <= sample_in;
      old_valid_ff  <= old_valid_in;
      rsp_energy_ff <= rsp_energy_in;
   end

   // ring memory: read of the oldest slot at acceptance, write in ST_SQ_OLD
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[idx_ff] <= sample_ff;
      end
      rd_data_ff <= ring[idx_ff];
   end

`ifndef SYNTH
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= MAX_FILL)
      else $error("fill count beyond ring depth");

   a_idx_in_fill : assert property (@(posedge clock) disable iff (reset)
      FILL_W'(idx_ff) <= fill_ff)
      else $error("index points past the written prefix");

   a_clear_zero : assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == OP_CLEAR) |=> (energy_ff == '0 && idx_ff == '0))
      else $error("clear did not zero energy and index");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside result load");
`endif

endmodule
`default_nettype wire
